### design/mimu_pkg.sv
// Package for the modular inverse multiply unit.
// Holds the fixed word widths and the default modulus width.
// No dependencies.
package mimu_pkg;

    // Width of the key, multiplier and index words on the ports.
    localparam int DATA_W       = 64;
    // Default modulus exponent: results are reduced mod 2^WIDTH.
    localparam int MIMU_WIDTH   = 64;
    // Half word for the 32x32 partial-product multiplier.
    localparam int HALF_W       = DATA_W / 2;

endpackage : mimu_pkg

### design/modular_inverse_multiply_unit.sv
// Modular inverse multiply unit: index = key * inv(multiplier) mod 2^WIDTH.
// Top level; single module. Depends on mimu_pkg for word widths.
//
// channel  | direction | handshake                     | payload
// ---------+-----------+-------------------------------+------------------------------
// input    | in        | i_in_valid / o_in_ready       | i_key_value[63:0]
// result   | out       | o_out_valid / i_out_ready     | o_index_value[63:0],
//          |           |                               | o_no_inverse
// config   | in        | i_cfg_wr_en (no wait)         | i_cfg_wr_data[63:0]
//
// Sequence: a word is taken in idle, then each Euclid step grows the aligned divisor
//   and subtracts it back down; the align state sees the zero remainder and the
//   shared 32x32 multiplier forms the final product. The single compare/subtract/shift
//   datapath runs one quotient bit per cycle. A multiplier with a zero residue
//   skips Euclid.
// Reset: synchronous, active low; clears the sequencer, the result valid and
//   loads the multiplier register with 1.
// Stalls: a finished result waits in the output register while the next key is
//   taken; the sequencer holds its last multiply cycle only if that register is
//   still full.
module modular_inverse_multiply_unit
    import mimu_pkg::*;
#(
    parameter int WIDTH = MIMU_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_wr_en,
    input  logic [DATA_W-1:0] i_cfg_wr_data,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [DATA_W-1:0] i_key_value,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_index_value,
    output logic              o_no_inverse
);

    localparam int SW = $clog2(WIDTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SUB,
        ST_MUL
    } t_state;

    t_state            r_state;
    logic [DATA_W-1:0] r_mult;        // multiplier register p
    logic [DATA_W-1:0] r_key;         // captured key word
    logic              r_no_inv;
    // Euclid state: divide r_a by r_b, r_db = r_b << r_s is the aligned divisor.
    logic [WIDTH:0]    r_a;
    logic [WIDTH-1:0]  r_b;
    logic [WIDTH+1:0]  r_db;
    logic [SW-1:0]     r_s;
    // Bezout coefficients, kept mod 2^WIDTH.
    logic [WIDTH-1:0]  r_x0;
    logic [WIDTH-1:0]  r_x1;
    // Final product over three partial products.
    logic [1:0]        r_mph;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_index;
    logic              r_out_no_inv;

    // Datapath shared by all Euclid steps.
    logic              w_b_zero;
    logic              w_grow;
    logic              w_take;
    logic [WIDTH:0]    w_a_sub;
    logic [WIDTH-1:0]  w_dx;
    logic [WIDTH-1:0]  w_x0_sub;
    logic [WIDTH-1:0]  w_r0;

    // Shared 32x32 multiplier.
    logic [DATA_W-1:0] w_inv;
    logic [HALF_W-1:0] w_mop_a;
    logic [HALF_W-1:0] w_mop_b;
    logic [DATA_W-1:0] w_mprod;
    logic [DATA_W-1:0] w_acc_next;
    logic [WIDTH-1:0]  w_index_w;
    logic              w_out_free;
    logic              w_in_acc;
    logic              w_load;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_r0      = r_mult[WIDTH-1:0];
    // Last multiply cycle with room in the output register: load the result word.
    assign w_load    = (r_state == ST_MUL) && (r_mph == 2'd3) && w_out_free;

    assign w_b_zero  = (r_b == '0);
    // Grow the divisor while twice it still fits under the dividend.
    assign w_grow    = ({r_db[WIDTH:0], 1'b0} <= {1'b0, r_a});
    assign w_take    = (r_db <= {1'b0, r_a});
    assign w_a_sub   = w_take ? (r_a - r_db[WIDTH:0]) : r_a;
    // Quotient bit at position s removes x1 << s from x0.
    assign w_dx      = r_x1 << r_s;
    assign w_x0_sub  = w_take ? (r_x0 - w_dx) : r_x0;

    // Low word of key * inv: kL*iL + ((kH*iL + kL*iH) << 32).
    assign w_inv = DATA_W'(r_x0);
    always_comb begin
        w_mop_a = r_key[HALF_W-1:0];
        w_mop_b = w_inv[HALF_W-1:0];
        case (r_mph)
            2'd1:    w_mop_a = r_key[DATA_W-1:HALF_W];
            2'd2:    w_mop_b = w_inv[DATA_W-1:HALF_W];
            default: ;
        endcase
    end
    assign w_mprod    = DATA_W'(w_mop_a) * DATA_W'(w_mop_b);
    assign w_acc_next = (r_mph == 2'd1) ? (r_acc + r_prod)
                                        : (r_acc + (r_prod << HALF_W));
    assign w_index_w  = w_acc_next[WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mult      <= DATA_W'(1);
            r_out_valid <= 1'b0;
            r_mph       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mult <= i_cfg_wr_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_key    <= i_key_value;
                        r_no_inv <= !r_mult[0];
                        // First step against 2^WIDTH: start dividing 2^WIDTH by p.
                        r_a      <= (WIDTH + 1)'(1) << WIDTH;
                        r_b      <= w_r0;
                        r_db     <= (WIDTH + 2)'(w_r0);
                        r_s      <= '0;
                        r_x0     <= '0;
                        r_x1     <= WIDTH'(1);
                        r_mph    <= '0;
                        // A zero residue ends Euclid at once with coefficient 0.
                        r_state  <= (w_r0 == '0) ? ST_MUL : ST_ALIGN;
                    end
                end
                ST_ALIGN: begin
                    if (w_b_zero) begin
                        r_mph   <= '0;
                        r_state <= ST_MUL;
                    end else if (w_grow) begin
                        r_db <= {r_db[WIDTH:0], 1'b0};
                        r_s  <= r_s + SW'(1);
                    end else begin
                        r_state <= ST_SUB;
                    end
                end
                ST_SUB: begin
                    if (r_s == '0) begin
                        // Step done: rotate (a, b) and (x0, x1).
                        r_a     <= {1'b0, r_b};
                        r_b     <= w_a_sub[WIDTH-1:0];
                        r_db    <= (WIDTH + 2)'(w_a_sub[WIDTH-1:0]);
                        r_x0    <= r_x1;
                        r_x1    <= w_x0_sub;
                        r_state <= ST_ALIGN;
                    end else begin
                        r_a  <= w_a_sub;
                        r_x0 <= w_x0_sub;
                        r_db <= {1'b0, r_db[WIDTH+1:1]};
                        r_s  <= r_s - SW'(1);
                    end
                end
                ST_MUL: begin
                    case (r_mph)
                        2'd0: begin
                            r_acc  <= '0;
                            r_prod <= w_mprod;
                            r_mph  <= 2'd1;
                        end
                        2'd1, 2'd2: begin
                            r_acc  <= w_acc_next;
                            r_prod <= w_mprod;
                            r_mph  <= r_mph + 2'd1;
                        end
                        default: begin
                            // Hold the last cycle until the output register frees.
                            if (w_out_free) begin
                                r_index      <= DATA_W'(w_index_w);
                                r_out_no_inv <= r_no_inv;
                                r_state      <= ST_IDLE;
                            end
                        end
                    endcase
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_index_value = r_index;
    assign o_no_inverse  = r_out_no_inv;

    // Aligned divisor never passes the dividend while growing.
    a_db_le_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALIGN && !w_b_zero) |-> (r_db <= {1'b0, r_a}))
        else $error("aligned divisor exceeds dividend");

    a_s_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALIGN || r_state == ST_SUB) |-> (r_s <= SW'(WIDTH)))
        else $error("shift count out of range");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a word without leaving idle");

    a_result_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_mph == 2'd3 && w_out_free)
            |=> (o_out_valid && o_no_inverse == $past(r_no_inv)))
        else $error("result word not loaded at end of multiply");

endmodule : modular_inverse_multiply_unit
